/* src/pidt_pkg.sv */
package pidt_pkg;

  localparam int SIG_W      = 32;
  localparam int GAIN_W     = 48;
  localparam int TIME_W     = 47;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_TAU    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MAX    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MIN    = 3'd6;

  localparam logic [TIME_W-1:0] RST_SAMPLE_PERIOD = 47'd21475;
  localparam logic [TIME_W-1:0] RST_FILTER_TAU    = 47'd42949672960;
  localparam logic [SIG_W-1:0]  RST_OUTPUT_MAX    = 32'd327680;

  // Shared multiplier: magnitude operands, one 8 bit digit of b per step
  localparam int MUL_A_W    = 64;
  localparam int MUL_B_W    = 50;
  localparam int MUL_DIG_W  = 8;
  localparam int MUL_DIGITS = 7;
  localparam int MUL_BS_W   = MUL_DIG_W * MUL_DIGITS;
  localparam int MUL_P_W    = MUL_A_W + MUL_BS_W;

  // Serial divider for the derivative filter
  localparam int NUM_W   = 84;
  localparam int DEN_W   = 49;
  localparam int DIV_Q_W = 34;

endpackage

/* src/pidt_if.sv */
interface pidt_in_if;
  logic                             valid;
  logic                             ready;
  logic [pidt_pkg::SIG_W-1:0]       target_value;
  logic [pidt_pkg::SIG_W-1:0]       measured_value;
  modport source (output valid, target_value, measured_value, input ready);
  modport sink (input valid, target_value, measured_value, output ready);
endinterface

interface pidt_out_if;
  logic                             valid;
  logic                             ready;
  logic [pidt_pkg::SIG_W-1:0]       drive_value;
  modport source (output valid, drive_value, input ready);
  modport sink (input valid, drive_value, output ready);
endinterface

interface pidt_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pidt_pkg::CFG_IDX_W-1:0]    index;
  logic [pidt_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/pidt_mul.sv */
module pidt_mul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [pidt_pkg::MUL_A_W-1:0]      a_i,
  input  logic [pidt_pkg::MUL_B_W-1:0]      b_i,
  output logic                              done_o,
  output logic [pidt_pkg::MUL_P_W-1:0]      mag_o,
  output logic                              neg_o
);

  localparam int AW  = pidt_pkg::MUL_A_W;
  localparam int BW  = pidt_pkg::MUL_B_W;
  localparam int DW  = pidt_pkg::MUL_DIG_W;
  localparam int BSW = pidt_pkg::MUL_BS_W;
  localparam int PW  = pidt_pkg::MUL_P_W;
  localparam int CW  = $clog2(pidt_pkg::MUL_DIGITS);
  localparam logic [CW-1:0] LAST = CW'(pidt_pkg::MUL_DIGITS - 1);

  logic [AW-1:0]    a_mag_q, a_mag_d;
  logic [BSW-1:0]   b_sr_q, b_sr_d;
  logic [PW-1:0]    acc_q, acc_d;
  logic             neg_q, neg_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [AW+DW-1:0] part;
  logic [AW+DW-1:0] sum;
  logic [BW-1:0]    b_mag;

  assign part = a_mag_q * b_sr_q[DW-1:0];
  assign sum  = {{DW{1'b0}}, acc_q[PW-1:BSW]} + part;
  assign b_mag = b_i[BW-1] ? BW'(-b_i) : b_i;

  always_comb begin
    a_mag_d = a_mag_q;
    b_sr_d  = b_sr_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (busy_q) begin
      // add this digit's partial product at the top, shift the lot down one digit
      acc_d  = {sum, acc_q[BSW-1:DW]};
      b_sr_d = {{DW{1'b0}}, b_sr_q[BSW-1:DW]};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      a_mag_d = a_i[AW-1] ? AW'(-a_i) : a_i;
      b_sr_d  = {{(BSW-BW){1'b0}}, b_mag};
      acc_d   = '0;
      neg_d   = a_i[AW-1] ^ b_i[BW-1];
      cnt_d   = '0;
      busy_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_mag_q <= a_mag_d;
    b_sr_q  <= b_sr_d;
    acc_q   <= acc_d;
    neg_q   <= neg_d;
  end

  assign done_o = done_q;
  assign mag_o  = acc_q;
  assign neg_o  = neg_q;

endmodule

/* src/pidt_div.sv */
module pidt_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [pidt_pkg::DEN_W-1:0]        hi_i,
  input  logic [pidt_pkg::DIV_Q_W-1:0]      lo_i,
  input  logic [pidt_pkg::DEN_W-1:0]        den_i,
  output logic                              done_o,
  output logic [pidt_pkg::DIV_Q_W-1:0]      q_o,
  output logic                              round_o
);

  localparam int DNW = pidt_pkg::DEN_W;
  localparam int QW  = pidt_pkg::DIV_Q_W;
  localparam int CW  = $clog2(QW);
  localparam logic [CW-1:0] LAST = CW'(QW - 1);

  logic [DNW-1:0] rem_q, rem_d;
  logic [QW-1:0]  sr_q, sr_d;
  logic [DNW-1:0] den_q, den_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [DNW:0]   trial;
  logic [DNW:0]   diff;
  logic           ge;

  assign trial = {rem_q, sr_q[QW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    sr_d   = sr_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (busy_q) begin
      // restoring step: dividend bits leave at the top, quotient bits enter below
      rem_d = ge ? diff[DNW-1:0] : trial[DNW-1:0];
      sr_d  = {sr_q[QW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      rem_d  = hi_i;
      sr_d   = lo_i;
      den_d  = den_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sr_q  <= sr_d;
    den_q <= den_d;
  end

  assign done_o  = done_q;
  assign q_o     = sr_q;
  assign round_o = {rem_q, 1'b0} >= {1'b0, den_q};

endmodule

/* src/pid_controller_tustin_antiwindup.sv */
// PID controller with trapezoidal integrator clamp and Tustin-filtered derivative.
// in_if carries one request per control sample: target_value and measured_value,
// signed Q16.16. out_if returns one drive_value per request, clamped to the limits.
// cfg_if writes the seven registers by index (gains, sample period, filter time
// constant, drive limits); it is always ready and is to be used only while idle.
// An unknown index is ignored.
// A request runs through a setup state, five products on the shared shift-add
// multiplier (8 bit digits), a check state, the serial divider, an update state
// and an output state. When the filter denominator is zero or the quotient
// saturates the divider is skipped. One request is in work at a time and in_if is
// ready in the cycle after the result is loaded, so a new request is taken only
// once the previous result has been loaded.
// The result sits in an output register; in_if is ready again as soon as it is
// loaded, even while the receiver stalls. A finished result that meets a full
// output register waits there and holds in_if not ready.
// Reset clears the integrator, previous error, derivative and previous measurement,
// and loads the register defaults.
module pid_controller_tustin_antiwindup (
  input  logic        clk_i,
  input  logic        rst_ni,
  pidt_in_if.sink     in_if,
  pidt_out_if.source  out_if,
  pidt_cfg_if.sink    cfg_if
);

  localparam int SW  = pidt_pkg::SIG_W;
  localparam int GW  = pidt_pkg::GAIN_W;
  localparam int TW  = pidt_pkg::TIME_W;
  localparam int AW  = pidt_pkg::MUL_A_W;
  localparam int BW  = pidt_pkg::MUL_B_W;
  localparam int PW  = pidt_pkg::MUL_P_W;
  localparam int NW  = pidt_pkg::NUM_W;
  localparam int DNW = pidt_pkg::DEN_W;
  localparam int QW  = pidt_pkg::DIV_Q_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DCHK  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  // Ki*T goes first so that it is registered before the integrator product reads it
  localparam logic [2:0] OP_KIT   = 3'd0;
  localparam logic [2:0] OP_KP    = 3'd1;
  localparam logic [2:0] OP_ACC   = 3'd2;
  localparam logic [2:0] OP_DMEAS = 3'd3;
  localparam logic [2:0] OP_DFILT = 3'd4;

  localparam logic [SW-1:0] S32_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] S32_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [62:0]   BIG_MAG = {1'b1, 62'd0};

  function automatic logic [PW-1:0] rnd_shr(input logic [PW-1:0] m, input int unsigned sh);
    logic [PW-1:0] half;
    half = PW'(1) << (sh - 1);
    return (m + half) >> sh;
  endfunction

  // configuration
  logic [GW-1:0] kp_q, ki_q, kd_q;
  logic [TW-1:0] tp_q, tau_q;
  logic [SW-1:0] omax_q, omin_q;

  // controller state
  logic [SW-1:0] ia_q, le_q, df_q, lm_q;
  logic [SW-1:0] ia_d;

  // per-request working registers
  logic [2:0]    st_q, st_d;
  logic [2:0]    op_q, op_nx;
  logic [SW-1:0] fb_q, err_q;
  logic [32:0]   sum_q, dfb_q;
  logic [GW-1:0] p_q;
  logic [AW-1:0] kit_q;
  logic [AW-1:0] integ_q;
  logic [NW-1:0] prodd_q, num_q;
  logic          nneg_q;
  logic [SW-1:0] d_q;
  logic [SW-1:0] out_q;
  logic          out_valid_q;

  logic          in_fire, out_fire, out_load;
  logic [32:0]   diff_in;
  logic [SW-1:0] err_in;
  logic          mul_start, mul_done, mul_neg;
  logic [PW-1:0] mul_mag;
  logic [AW-1:0] mul_a;
  logic [BW-1:0] mul_b;
  logic [PW-1:0] r32, r33;
  logic [NW-1:0] prod_s;
  logic [AW:0]   integ_sum;
  logic [NW-1:0] num_mag;
  logic [DNW-1:0] den;
  logic          div_start, div_done, div_round;
  logic [QW-1:0] div_q;
  logic [QW:0]   qr;
  logic [SW-1:0] d_div;
  logic [GW:0]   maxi, mini;
  logic [AW-1:0] integ_c;
  logic [GW+1:0] drive_s;
  logic [SW-1:0] drive;
  logic [GW:0]   p_ext, omax_ext, omin_ext;

  assign in_fire  = in_if.valid && in_if.ready;
  assign out_fire = out_if.valid && out_if.ready;
  assign in_if.ready  = (st_q == ST_IDLE);
  assign cfg_if.ready = 1'b1;

  // error at the input, saturated to 32 bits
  assign diff_in = {in_if.target_value[SW-1], in_if.target_value}
                 - {in_if.measured_value[SW-1], in_if.measured_value};
  always_comb begin
    if (diff_in[32] != diff_in[31]) begin
      err_in = diff_in[32] ? S32_MIN : S32_MAX;
    end else begin
      err_in = diff_in[SW-1:0];
    end
  end

  // operand selection for the product being started
  assign op_nx     = (st_q == ST_SETUP) ? OP_KIT : op_q + 3'd1;
  assign mul_start = (st_q == ST_SETUP) || (st_q == ST_MUL && mul_done && op_q != OP_DFILT);

  always_comb begin
    case (op_nx)
      OP_KP: begin
        mul_a = {{(AW-GW){kp_q[GW-1]}}, kp_q};
        mul_b = {{(BW-SW){err_q[SW-1]}}, err_q};
      end
      OP_KIT: begin
        mul_a = {{(AW-GW){ki_q[GW-1]}}, ki_q};
        mul_b = {{(BW-TW){1'b0}}, tp_q};
      end
      OP_ACC: begin
        mul_a = kit_q;
        mul_b = {{(BW-33){sum_q[32]}}, sum_q};
      end
      OP_DMEAS: begin
        mul_a = {{(AW-GW-1){kd_q[GW-1]}}, kd_q, 1'b0};
        mul_b = {{(BW-33){dfb_q[32]}}, dfb_q};
      end
      OP_DFILT: begin
        mul_a = AW'({2'b00, tau_q, 1'b0} - {3'b000, tp_q});
        mul_a = {{(AW-DNW){mul_a[DNW-1]}}, mul_a[DNW-1:0]};
        mul_b = {{(BW-SW){df_q[SW-1]}}, df_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pidt_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .mag_o   (mul_mag),
    .neg_o   (mul_neg)
  );

  assign r32    = rnd_shr(mul_mag, 32);
  assign r33    = rnd_shr(mul_mag, 33);
  assign prod_s = mul_neg ? NW'(-mul_mag[NW-1:0]) : mul_mag[NW-1:0];
  assign integ_sum = {{(AW+1-SW){ia_q[SW-1]}}, ia_q}
                   + (mul_neg ? (AW+1)'(-{2'b00, r33[62:0]}) : {2'b00, r33[62:0]});

  // derivative filter division
  assign den     = {1'b0, tau_q, 1'b0} + {2'b00, tp_q};
  assign num_mag = num_q[NW-1] ? NW'(-num_q) : num_q;

  assign div_start = (st_q == ST_DCHK) && (den != '0) && !(num_mag[NW-1:QW] >= {1'b0, den});

  pidt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .hi_i    (num_mag[NW-2:QW]),
    .lo_i    (num_mag[QW-1:0]),
    .den_i   (den),
    .done_o  (div_done),
    .q_o     (div_q),
    .round_o (div_round)
  );

  assign qr = {1'b0, div_q} + {{QW{1'b0}}, div_round};
  always_comb begin
    // the derivative is the negated quotient
    if (nneg_q) begin
      d_div = (qr > {{(QW+1-SW){1'b0}}, S32_MAX}) ? S32_MAX : qr[SW-1:0];
    end else begin
      d_div = (qr > {{(QW+1-SW){1'b0}}, 1'b1, {(SW-1){1'b0}}}) ? S32_MIN : SW'(-qr);
    end
  end

  // integrator clamp against the room the proportional term leaves
  assign p_ext    = {p_q[GW-1], p_q};
  assign omax_ext = {{(GW+1-SW){omax_q[SW-1]}}, omax_q};
  assign omin_ext = {{(GW+1-SW){omin_q[SW-1]}}, omin_q};
  assign maxi = ($signed(omax_ext) > $signed(p_ext)) ? omax_ext - p_ext : '0;
  assign mini = ($signed(omin_ext) < $signed(p_ext)) ? omin_ext - p_ext : '0;

  always_comb begin
    if ($signed(integ_q) > $signed({{(AW-GW-1){maxi[GW]}}, maxi})) begin
      integ_c = {{(AW-GW-1){maxi[GW]}}, maxi};
    end else if ($signed(integ_q) < $signed({{(AW-GW-1){mini[GW]}}, mini})) begin
      integ_c = {{(AW-GW-1){mini[GW]}}, mini};
    end else begin
      integ_c = integ_q;
    end
    if ($signed(integ_c) > $signed({{(AW-SW){1'b0}}, S32_MAX})) begin
      ia_d = S32_MAX;
    end else if ($signed(integ_c) < $signed({{(AW-SW){1'b1}}, S32_MIN})) begin
      ia_d = S32_MIN;
    end else begin
      ia_d = integ_c[SW-1:0];
    end
  end

  assign drive_s = {p_q[GW-1], p_q[GW-1], p_q}
                 + {{(GW+2-SW){ia_q[SW-1]}}, ia_q}
                 + {{(GW+2-SW){df_q[SW-1]}}, df_q};
  always_comb begin
    if ($signed(drive_s) > $signed({omax_ext[GW], omax_ext})) begin
      drive = omax_q;
    end else if ($signed(drive_s) < $signed({omin_ext[GW], omin_ext})) begin
      drive = omin_q;
    end else begin
      drive = drive_s[SW-1:0];
    end
  end

  assign out_load = (st_q == ST_OUT) && (!out_valid_q || out_if.ready);

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:  if (in_fire) st_d = ST_SETUP;
      ST_SETUP: st_d = ST_MUL;
      ST_MUL:   if (mul_done && op_q == OP_DFILT) st_d = ST_DCHK;
      ST_DCHK:  st_d = div_start ? ST_DIV : ST_FIN;
      ST_DIV:   if (div_done) st_d = ST_FIN;
      ST_FIN:   st_d = ST_OUT;
      ST_OUT:   if (out_load) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      op_q        <= OP_KIT;
      out_valid_q <= 1'b0;
      kp_q        <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      tp_q        <= pidt_pkg::RST_SAMPLE_PERIOD;
      tau_q       <= pidt_pkg::RST_FILTER_TAU;
      omax_q      <= pidt_pkg::RST_OUTPUT_MAX;
      omin_q      <= '0;
      ia_q        <= '0;
      le_q        <= '0;
      df_q        <= '0;
      lm_q        <= '0;
    end else begin
      st_q <= st_d;
      if (mul_start) op_q <= op_nx;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_if.valid) begin
        case (cfg_if.index)
          pidt_pkg::REG_PROP_GAIN:     kp_q   <= cfg_if.data[GW-1:0];
          pidt_pkg::REG_INTEGRAL_GAIN: ki_q   <= cfg_if.data[GW-1:0];
          pidt_pkg::REG_DERIV_GAIN:    kd_q   <= cfg_if.data[GW-1:0];
          pidt_pkg::REG_SAMPLE_PERIOD: tp_q   <= cfg_if.data[TW-1:0];
          pidt_pkg::REG_FILTER_TAU:    tau_q  <= cfg_if.data[TW-1:0];
          pidt_pkg::REG_OUTPUT_MAX:    omax_q <= cfg_if.data[SW-1:0];
          pidt_pkg::REG_OUTPUT_MIN:    omin_q <= cfg_if.data[SW-1:0];
          default: ;
        endcase
      end
      if (st_q == ST_FIN) begin
        ia_q <= ia_d;
        le_q <= err_q;
        lm_q <= fb_q;
        df_q <= d_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      fb_q  <= in_if.measured_value;
      err_q <= err_in;
      sum_q <= {err_in[SW-1], err_in} + {le_q[SW-1], le_q};
      dfb_q <= {in_if.measured_value[SW-1], in_if.measured_value} - {lm_q[SW-1], lm_q};
    end
    if (st_q == ST_MUL && mul_done) begin
      case (op_q)
        OP_KP:    p_q <= mul_neg ? GW'(-r32[GW-1:0]) : r32[GW-1:0];
        OP_KIT: begin
          if (r32 > {{(PW-63){1'b0}}, BIG_MAG}) begin
            kit_q <= mul_neg ? AW'(-{1'b0, BIG_MAG}) : {1'b0, BIG_MAG};
          end else begin
            kit_q <= mul_neg ? AW'(-{1'b0, r32[62:0]}) : {1'b0, r32[62:0]};
          end
        end
        OP_ACC: begin
          // hold the integrator candidate within plus or minus 2^62
          if ($signed(integ_sum) > $signed({2'b00, BIG_MAG})) begin
            integ_q <= {1'b0, BIG_MAG};
          end else if ($signed(integ_sum) < $signed(-{2'b00, BIG_MAG})) begin
            integ_q <= AW'(-{1'b0, BIG_MAG});
          end else begin
            integ_q <= integ_sum[AW-1:0];
          end
        end
        OP_DMEAS: prodd_q <= prod_s;
        OP_DFILT: num_q   <= prodd_q + prod_s;
        default: ;
      endcase
    end
    if (st_q == ST_DCHK) begin
      nneg_q <= num_q[NW-1];
      if (den == '0) begin
        d_q <= '0;
      end else if (!div_start) begin
        d_q <= num_q[NW-1] ? S32_MAX : S32_MIN;
      end
    end
    if (st_q == ST_DIV && div_done) d_q <= d_div;
    if (out_load) out_q <= drive;
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.drive_value = out_q;

endmodule

/* src/pidt_chk.sv */
module pidt_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] drive_value_i
);

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_i;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(drive_value_i))
    else $error("result changed or dropped while stalled");

  // one request at a time
  a_busy_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_i)
    else $error("request taken while busy");

  // in_if is not ready again while the multiply sequence is still running
  a_busy_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> ##16 !in_ready_i)
    else $error("request finished too early");

endmodule

bind pid_controller_tustin_antiwindup pidt_chk u_pidt_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_if.valid),
  .in_ready_i    (in_if.ready),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .drive_value_i (out_if.drive_value)
);
